/* rtl/bounded_list_insert_delete_search_top_defines.svh */
// ----------------------------------------------------------------------------
// Bounded list assertion macros
// Shared concurrent assertion wrappers. Define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_LIST_INSERT_DELETE_SEARCH_TOP_DEFINES_SVH
`define BOUNDED_LIST_INSERT_DELETE_SEARCH_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked on every rising clock edge outside of reset.
`define BLIST_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every rising clock edge, reset included.
`define BLIST_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BLIST_ASSERT(label, clk, rst, prop, msg)
`define BLIST_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

/* rtl/blist_pkg.sv */
// ----------------------------------------------------------------------------
// Bounded list package
// Shared widths, operation and status codes, and controller/datapath links.
// ----------------------------------------------------------------------------
package blist_pkg;

   localparam int DEPTH_DEF       = 16;
   localparam int VALUE_WIDTH_DEF = 32;

   localparam int FUNC_W   = 2;
   localparam int POS_W    = 4;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int LEN_W    = 5;

   // Request tdata: func, position, value, padded to whole bytes.
   localparam int REQ_TDATA_W = 40;
   // Response tdata: status, found, length.
   localparam int RSP_TDATA_W = 8;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_APPEND = 2'd0,
      FUNC_INSERT = 2'd1,
      FUNC_DELETE = 2'd2,
      FUNC_FIND   = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;       // capture a request and set up the index
      logic       rd;         // read the entry beside the index, at it for find
      logic       wr_shift;   // write the read entry back at the index
      logic       find_step;  // compare the read entry with the key
      logic       wr_val;     // write the request value at the index, grow
      logic       cnt_dec;    // shrink the list by one
      logic       rsp_load;   // load the response register
      status_type code;       // status reported by rsp_load
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      func_type func;
      logic     full;
      logic     range_bad;
      logic     more;
      logic     hit;
   } sts_type;

endpackage

/* rtl/blist_dp.sv */
// ----------------------------------------------------------------------------
// Bounded list datapath
// Entry memory, live count, sweep index, key compare and response register.
// ----------------------------------------------------------------------------
`include "bounded_list_insert_delete_search_top_defines.svh"

module blist_dp #(
   parameter int DEPTH       = blist_pkg::DEPTH_DEF,
   parameter int VALUE_WIDTH = blist_pkg::VALUE_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  blist_pkg::cmd_type             cmd,
   output blist_pkg::sts_type             sts,
   input  blist_pkg::func_type            req_func,
   input  logic [blist_pkg::POS_W-1:0]    req_position,
   input  logic [blist_pkg::DATA_W-1:0]   req_value,
   output blist_pkg::status_type          rsp_status,
   output logic                           rsp_found,
   output logic [blist_pkg::LEN_W-1:0]    rsp_length
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = (CW > blist_pkg::POS_W) ? CW : blist_pkg::POS_W;
   localparam int LW = (CW > blist_pkg::LEN_W) ? CW : blist_pkg::LEN_W;

   logic [VALUE_WIDTH-1:0] entries_ff [DEPTH];
   logic [VALUE_WIDTH-1:0] rdata_ff;

   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          idx_ff, idx_in;
   blist_pkg::func_type    func_ff, func_in;
   logic [PW-1:0]          pos_ff, pos_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic                   hit_ff, hit_in;

   blist_pkg::status_type  rsp_status_ff, rsp_status_in;
   logic                   rsp_found_ff, rsp_found_in;
   logic [blist_pkg::LEN_W-1:0] rsp_length_ff, rsp_length_in;

   logic [PW-1:0]          cnt_pw;
   logic [PW-1:0]          idx_pw;
   logic [CW:0]            idx_next_wide;
   logic [CW-1:0]          rd_idx;
   logic [LW-1:0]          len_ext;

   assign cnt_pw        = PW'(count_ff);
   assign idx_pw        = PW'(idx_ff);
   assign idx_next_wide = (CW + 1)'(idx_ff) + (CW + 1)'(1);
   assign len_ext       = LW'(count_ff);

   // Status toward the controller.
   always_comb begin
      sts.func = func_ff;
      sts.full = (count_ff == CW'(DEPTH));
      sts.hit  = (rdata_ff == val_ff);
      unique case (func_ff)
         blist_pkg::FUNC_INSERT: begin
            sts.range_bad = (pos_ff > cnt_pw);
            sts.more      = (idx_pw > pos_ff);
            rd_idx        = idx_ff - CW'(1);
         end
         blist_pkg::FUNC_DELETE: begin
            sts.range_bad = (pos_ff >= cnt_pw);
            sts.more      = (idx_next_wide < (CW + 1)'(count_ff));
            rd_idx        = idx_ff + CW'(1);
         end
         blist_pkg::FUNC_FIND: begin
            sts.range_bad = 1'b0;
            sts.more      = (idx_ff < count_ff);
            rd_idx        = idx_ff;
         end
         default: begin
            sts.range_bad = 1'b0;
            sts.more      = 1'b0;
            rd_idx        = idx_ff;
         end
      endcase
   end

   // Next-state logic of the working registers.
   always_comb begin
      count_in      = count_ff;
      idx_in        = idx_ff;
      func_in       = func_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      hit_in        = hit_ff;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_length_in = rsp_length_ff;

      if (cmd.wr_val) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CW'(1);
      end

      if (cmd.load) begin
         func_in = req_func;
         pos_in  = PW'(req_position);
         val_in  = VALUE_WIDTH'(req_value);
         hit_in  = 1'b0;
         // Insert sweeps down from the end, delete up from the position.
         unique case (req_func)
            blist_pkg::FUNC_APPEND: idx_in = count_ff;
            blist_pkg::FUNC_INSERT: idx_in = count_ff;
            blist_pkg::FUNC_DELETE: idx_in = CW'(req_position);
            default:                idx_in = '0;
         endcase
      end else if (cmd.wr_shift) begin
         idx_in = (func_ff == blist_pkg::FUNC_INSERT) ? (idx_ff - CW'(1))
                                                      : (idx_ff + CW'(1));
      end else if (cmd.find_step) begin
         idx_in = idx_ff + CW'(1);
         hit_in = sts.hit;
      end

      if (cmd.rsp_load) begin
         rsp_status_in = cmd.code;
         rsp_found_in  = hit_ff;
         rsp_length_in = len_ext[blist_pkg::LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      func_ff       <= func_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      hit_ff        <= hit_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_length_ff <= rsp_length_in;
   end

   // Single write port, single registered read port.
   always_ff @(posedge clock) begin
      if (cmd.wr_shift || cmd.wr_val) begin
         entries_ff[idx_ff[AW-1:0]] <= cmd.wr_val ? val_ff : rdata_ff;
      end
      if (cmd.rd) begin
         rdata_ff <= entries_ff[rd_idx[AW-1:0]];
      end
   end

   assign rsp_status = rsp_status_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_length = rsp_length_ff;

   `BLIST_ASSERT(a_count_bound, clock, reset, (count_ff <= CW'(DEPTH)), "live count above capacity")
   `BLIST_ASSERT(a_wr_in_range, clock, reset, ((cmd.wr_shift || cmd.wr_val) |-> (idx_ff < CW'(DEPTH))), "memory write beyond capacity")
   `BLIST_ASSERT(a_dec_nonempty, clock, reset, (cmd.cnt_dec |-> (count_ff != '0)), "delete shrank an empty list")

endmodule

/* rtl/blist_ctrl.sv */
// ----------------------------------------------------------------------------
// Bounded list controller
// Sequences each request through checks, memory sweeps and the response.
// ----------------------------------------------------------------------------
`include "bounded_list_insert_delete_search_top_defines.svh"

module blist_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  blist_pkg::sts_type sts,
   output blist_pkg::cmd_type cmd
);

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_DECIDE  = 8'b0000_0010,
      ST_READ    = 8'b0000_0100,
      ST_SHIFT   = 8'b0000_1000,
      ST_COMPARE = 8'b0001_0000,
      ST_PUT     = 8'b0010_0000,
      ST_SHRINK  = 8'b0100_0000,
      ST_RESPOND = 8'b1000_0000
   } state_type;

   state_type             state_ff, state_in;
   blist_pkg::status_type code_ff, code_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      cmd      = '0;
      cmd.code = code_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            code_in = blist_pkg::STATUS_DONE;
            unique case (sts.func)
               blist_pkg::FUNC_APPEND: begin
                  if (sts.full) begin
                     code_in  = blist_pkg::STATUS_FULL;
                     state_in = ST_RESPOND;
                  end else begin
                     state_in = ST_PUT;
                  end
               end
               blist_pkg::FUNC_INSERT: begin
                  // A full list is reported ahead of a bad position.
                  if (sts.full) begin
                     code_in  = blist_pkg::STATUS_FULL;
                     state_in = ST_RESPOND;
                  end else if (sts.range_bad) begin
                     code_in  = blist_pkg::STATUS_RANGE;
                     state_in = ST_RESPOND;
                  end else if (sts.more) begin
                     state_in = ST_READ;
                  end else begin
                     state_in = ST_PUT;
                  end
               end
               blist_pkg::FUNC_DELETE: begin
                  if (sts.range_bad) begin
                     code_in  = blist_pkg::STATUS_RANGE;
                     state_in = ST_RESPOND;
                  end else if (sts.more) begin
                     state_in = ST_READ;
                  end else begin
                     state_in = ST_SHRINK;
                  end
               end
               default: begin
                  state_in = sts.more ? ST_READ : ST_RESPOND;
               end
            endcase
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = (sts.func == blist_pkg::FUNC_FIND) ? ST_COMPARE : ST_SHIFT;
         end
         ST_SHIFT: begin
            cmd.wr_shift = 1'b1;
            state_in     = ST_DECIDE;
         end
         ST_COMPARE: begin
            cmd.find_step = 1'b1;
            state_in      = sts.hit ? ST_RESPOND : ST_DECIDE;
         end
         ST_PUT: begin
            cmd.wr_val = 1'b1;
            state_in   = ST_RESPOND;
         end
         ST_SHRINK: begin
            cmd.cnt_dec = 1'b1;
            state_in    = ST_RESPOND;
         end
         ST_RESPOND: begin
            // Wait only while an earlier response is still unclaimed.
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = cmd.rsp_load | (rsp_valid_ff & ~rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         code_ff      <= blist_pkg::STATUS_DONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         code_ff      <= code_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   `BLIST_ASSERT(a_no_overwrite, clock, reset, (cmd.rsp_load |-> (!rsp_valid_ff || rsp_tready)), "response overwritten before taken")
   `BLIST_ASSERT(a_put_not_full, clock, reset, (cmd.wr_val |-> !sts.full), "value written into a full list")
   `BLIST_ASSERT(a_one_command, clock, reset, $onehot0({cmd.load, cmd.rd, cmd.wr_shift, cmd.find_step, cmd.wr_val, cmd.cnt_dec, cmd.rsp_load}), "several commands in one cycle")

endmodule

/* rtl/bounded_list_insert_delete_search_top.sv */
// ----------------------------------------------------------------------------
// Bounded list with insert, delete and search
// Fixed-capacity ordered list held in a memory with one write and one read
// port, one request at a time, one response per request.
// ----------------------------------------------------------------------------
// Each request carries an operation (append, insert at a position, delete
// at a position, find a value) and returns one response with a status
// (done, list full, position out of range), a found flag and the list length
// after the operation. The list lives in a memory with one write port and
// one registered read port, so insert and delete move one entry per step and
// find reads one entry per step; each step passes through check, read, and
// write or compare. The next request can be accepted at the edge after its
// predecessor's response is loaded, even if that response has not yet been
// taken; a new response waits only if the previous one is still unclaimed.
// No clearing pass is needed after reset: only live entries are ever read.
// ----------------------------------------------------------------------------
module bounded_list_insert_delete_search_top #(
   parameter int DEPTH       = blist_pkg::DEPTH_DEF,
   parameter int VALUE_WIDTH = blist_pkg::VALUE_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // func [1:0], position [5:2], value [37:6], zero pad [39:38].
   input  logic [blist_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // Response channel.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // status [1:0], found [2], length [7:3].
   output logic [blist_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   blist_pkg::cmd_type               cmd;
   blist_pkg::sts_type               sts;

   blist_pkg::func_type              req_func;
   logic [blist_pkg::POS_W-1:0]      req_position;
   logic [blist_pkg::DATA_W-1:0]     req_value;

   blist_pkg::status_type            rsp_status;
   logic                             rsp_found;
   logic [blist_pkg::LEN_W-1:0]      rsp_length;

   // Unpack the request fields; the top pad bits carry nothing.
   assign req_func     = blist_pkg::func_type'(req_tdata[1:0]);
   assign req_position = req_tdata[5:2];
   assign req_value    = req_tdata[37:6];

   // Pack the response fields, lowest field in the lowest bits.
   assign rsp_tdata = {rsp_length, rsp_found, rsp_status};

   // The controller owns the handshakes and the step sequence.
   blist_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // The datapath holds the list, the count and the response register.
   blist_dp #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_func     (req_func),
      .req_position (req_position),
      .req_value    (req_value),
      .rsp_status   (rsp_status),
      .rsp_found    (rsp_found),
      .rsp_length   (rsp_length)
   );

endmodule

/* tb/bounded_list_insert_delete_search_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bounded list insert/delete/search testbench
// Drives append, insert, delete and find requests into the list block over
// its request stream. Every request is predicted from a local copy of the
// list, and each response is checked in order. Directed corner cases come
// first, then long random runs with random idling, a long response
// hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module bounded_list_insert_delete_search_top_tb;

   localparam int DEPTH       = blist_pkg::DEPTH_DEF;
   // Longest request is a find that misses over a full list.
   localparam int TAIL_CYCLES = 80;
   // Cycles without any handshake before the run is declared hung. This must
   // clear the long response hold-off below by a wide margin.
   localparam int STALL_LIMIT = 3000;
   localparam int HOLD_CYCLES = 300;

   // One expected response.
   typedef struct {
      blist_pkg::status_type       status;
      logic                        found;
      logic [blist_pkg::LEN_W-1:0] length;
   } list_result_type;

   logic                              clock;
   logic                              reset;
   logic                              req_tvalid;
   logic                              req_tready;
   // func [1:0], position [5:2], value [37:6], zero pad [39:38].
   logic [blist_pkg::REQ_TDATA_W-1:0] req_tdata;
   logic                              rsp_tvalid;
   logic                              rsp_tready;
   // status [1:0], found [2], length [7:3].
   logic [blist_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   // Local copy of the list, updated as each request is accepted.
   logic [blist_pkg::DATA_W-1:0] list_entries [DEPTH];
   int                           list_len;

   list_result_type              pending_results [$];
   list_result_type              oldest_result;
   logic [blist_pkg::DATA_W-1:0] value_pool [8];

   int fail_count;
   int rsp_count;
   int stall_cycles;
   int rsp_wait_left;
   int rsp_hold_request;
   bit send_gaps_on;
   bit recv_gaps_on;
   bit list_growing;

   bounded_list_insert_delete_search_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 20 ns clock period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Applies one request to the local list and returns the response it
   // should produce. Only live entries are ever read.
   function automatic list_result_type apply_list_op(blist_pkg::func_type op,
                                                     logic [blist_pkg::POS_W-1:0] pos,
                                                     logic [blist_pkg::DATA_W-1:0] val);
      list_result_type res;
      int              i;
      res.status = blist_pkg::STATUS_DONE;
      res.found  = 1'b0;
      case (op)
         blist_pkg::FUNC_APPEND: begin
            if (list_len >= DEPTH) begin
               res.status = blist_pkg::STATUS_FULL;
            end else begin
               list_entries[list_len] = val;
               list_len++;
            end
         end
         blist_pkg::FUNC_INSERT: begin
            // The full check wins over the position check.
            if (list_len >= DEPTH) begin
               res.status = blist_pkg::STATUS_FULL;
            end else if (int'(pos) > list_len) begin
               res.status = blist_pkg::STATUS_RANGE;
            end else begin
               for (i = list_len; i > int'(pos); i--)
                  list_entries[i] = list_entries[i-1];
               list_entries[pos] = val;
               list_len++;
            end
         end
         blist_pkg::FUNC_DELETE: begin
            if (int'(pos) >= list_len) begin
               res.status = blist_pkg::STATUS_RANGE;
            end else begin
               for (i = int'(pos); i + 1 < list_len; i++)
                  list_entries[i] = list_entries[i+1];
               list_len--;
            end
         end
         default: begin
            for (i = 0; i < list_len; i++)
               if (list_entries[i] == val)
                  res.found = 1'b1;
         end
      endcase
      res.length = list_len[blist_pkg::LEN_W-1:0];
      return res;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      fail_count++;
      $display("ERROR: %0t ns response %0d %s: got %0h, expected %0h",
               $time, rsp_count, what, got, want);
   endtask

   // Sends one request. It is entered at a falling edge and returns at the
   // falling edge after acceptance, with tvalid still high so that a
   // back-to-back request needs no second assignment in the same step.
   task automatic send_request(blist_pkg::func_type op, logic [blist_pkg::POS_W-1:0] pos,
                               logic [blist_pkg::DATA_W-1:0] val);
      int              gap;
      list_result_type expected;
      gap = send_gaps_on ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, val, pos, op};
      do @(posedge clock); while (!req_tready);
      expected = apply_list_op(op, pos, val);
      pending_results.insert(pending_results.size(), expected);
      @(negedge clock);
   endtask

   // Stops offering requests and waits for every outstanding response.
   task automatic wait_results_drained;
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   // One random request. Most requests follow the current list contents so
   // that the list keeps sweeping between empty and full; the rest is noise.
   task automatic send_random_request;
      blist_pkg::func_type          op;
      logic [blist_pkg::POS_W-1:0]  pos;
      logic [blist_pkg::DATA_W-1:0] val;
      int                           pick;
      if ($urandom_range(0, 99) < 15) begin
         op  = blist_pkg::func_type'($urandom_range(0, 3));
         pos = blist_pkg::POS_W'($urandom_range(0, 15));
         val = $urandom;
      end else begin
         if (list_len >= DEPTH)
            list_growing = 1'b0;
         else if (list_len == 0)
            list_growing = 1'b1;
         pick = $urandom_range(0, 99);
         if (list_growing)
            op = (pick < 40) ? blist_pkg::FUNC_APPEND : (pick < 70) ? blist_pkg::FUNC_INSERT :
                 (pick < 80) ? blist_pkg::FUNC_DELETE : blist_pkg::FUNC_FIND;
         else
            op = (pick < 10) ? blist_pkg::FUNC_APPEND : (pick < 20) ? blist_pkg::FUNC_INSERT :
                 (pick < 75) ? blist_pkg::FUNC_DELETE : blist_pkg::FUNC_FIND;
         case (op)
            blist_pkg::FUNC_INSERT:
               pos = blist_pkg::POS_W'($urandom_range(0, (list_len < 15) ? list_len : 15));
            blist_pkg::FUNC_DELETE:
               pos = (list_len > 0) ? blist_pkg::POS_W'($urandom_range(0, list_len - 1)) : '0;
            default:
               pos = blist_pkg::POS_W'($urandom_range(0, 15));
         endcase
         // Half of the finds on a non-empty list look for a live value so hits are common.
         if (op == blist_pkg::FUNC_FIND && list_len > 0 && $urandom_range(0, 1) == 1)
            val = list_entries[$urandom_range(0, list_len - 1)];
         else if ($urandom_range(0, 3) == 0)
            val = $urandom;
         else
            val = value_pool[$urandom_range(0, 7)];
      end
      send_request(op, pos, val);
   endtask

   // Corner cases: empty list, position limits, insert at the end, and the
   // full list.
   task automatic test_directed_cases;
      int i;
      send_request(blist_pkg::FUNC_FIND,   4'd0,  32'h0000_0000);
      send_request(blist_pkg::FUNC_DELETE, 4'd0,  32'h0000_0000);
      send_request(blist_pkg::FUNC_INSERT, 4'd1,  32'h1111_1111);
      send_request(blist_pkg::FUNC_INSERT, 4'd0,  32'hFFFF_FFFF);
      send_request(blist_pkg::FUNC_APPEND, 4'd15, 32'h0000_0000);
      // Position equal to the length behaves as an append.
      send_request(blist_pkg::FUNC_INSERT, 4'd2,  32'hA5A5_A5A5);
      send_request(blist_pkg::FUNC_INSERT, 4'd0,  32'h5A5A_5A5A);
      send_request(blist_pkg::FUNC_FIND,   4'd9,  32'h0000_0000);
      send_request(blist_pkg::FUNC_DELETE, 4'd4,  32'h0000_0000);
      send_request(blist_pkg::FUNC_DELETE, 4'd3,  32'hFFFF_FFFF);
      for (i = 0; i < 13; i++)
         send_request(blist_pkg::FUNC_APPEND, 4'(i), $urandom);
      send_request(blist_pkg::FUNC_APPEND, 4'd0,  32'h1234_5678);
      send_request(blist_pkg::FUNC_INSERT, 4'd15, 32'h1234_5678);
      send_request(blist_pkg::FUNC_FIND,   4'd0,  32'hFFFF_FFFF);
      send_request(blist_pkg::FUNC_DELETE, 4'd15, 32'h0000_0000);
   endtask

   task automatic test_random_mixed(int n);
      int i;
      send_gaps_on = 1'b1;
      recv_gaps_on = 1'b1;
      for (i = 0; i < n; i++)
         send_random_request();
   endtask

   // Back-to-back requests with the response side always ready.
   task automatic test_no_idle_stretch(int n);
      int i;
      send_gaps_on = 1'b0;
      recv_gaps_on = 1'b0;
      for (i = 0; i < n; i++)
         send_random_request();
   endtask

   // The receiver holds off for a long stretch while requests keep coming,
   // so the block fills up and must stall its request side.
   task automatic test_response_hold_off;
      int i;
      send_gaps_on     = 1'b0;
      recv_gaps_on     = 1'b1;
      rsp_hold_request = HOLD_CYCLES;
      for (i = 0; i < 12; i++)
         send_random_request();
   endtask

   // The sender pauses until every outstanding response has returned.
   task automatic test_drain_pause;
      int i;
      send_gaps_on = 1'b1;
      recv_gaps_on = 1'b1;
      for (i = 0; i < 100; i++)
         send_random_request();
      wait_results_drained();
      for (i = 0; i < 100; i++)
         send_random_request();
   endtask

   // Blocks of requests with each side's idling switched on or off at random.
   task automatic test_random_gap_mix(int blocks);
      int b;
      int i;
      for (b = 0; b < blocks; b++) begin
         send_gaps_on = ($urandom_range(0, 2) != 0);
         recv_gaps_on = ($urandom_range(0, 2) != 0);
         for (i = 0; i < 50; i++)
            send_random_request();
      end
   endtask

   // Response side: the ready line follows a countdown that is reloaded with
   // a fresh random wait after each response and with the long hold-off on
   // request.
   always @(negedge clock) begin
      if (rsp_hold_request > 0) begin
         rsp_wait_left    = rsp_hold_request;
         rsp_hold_request = 0;
      end
      if (rsp_wait_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_wait_left--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Response checker: each response is compared with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_wait_left = recv_gaps_on ? $urandom_range(0, 13) : 0;
         if (pending_results.size() == 0) begin
            report_mismatch("response with nothing outstanding", rsp_tdata, 0);
         end else begin
            oldest_result = pending_results.pop_front();
            if (rsp_tdata[1:0] !== oldest_result.status)
               report_mismatch("status", rsp_tdata[1:0], oldest_result.status);
            if (rsp_tdata[2] !== oldest_result.found)
               report_mismatch("found", rsp_tdata[2], oldest_result.found);
            if (rsp_tdata[7:3] !== oldest_result.length)
               report_mismatch("length", rsp_tdata[7:3], oldest_result.length);
         end
         rsp_count++;
      end
   end

   // Watchdog: a run with no handshake on either side for too long is hung.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("bounded_list_insert_delete_search_top: mismatch");
         $finish;
      end
   end

   initial begin
      int i;
      clock            = 1'b0;
      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      rsp_tready       = 1'b0;
      list_len         = 0;
      fail_count       = 0;
      rsp_count        = 0;
      stall_cycles     = 0;
      rsp_wait_left    = 0;
      rsp_hold_request = 0;
      send_gaps_on     = 1'b1;
      recv_gaps_on     = 1'b1;
      list_growing     = 1'b1;
      // A small pool of values makes repeated values and find hits likely.
      value_pool[0] = 32'h0000_0000;
      value_pool[1] = 32'hFFFF_FFFF;
      for (i = 2; i < 8; i++)
         value_pool[i] = $urandom;

      // Reset is released at a falling edge.
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_cases();
      test_random_mixed(600);
      test_no_idle_stretch(150);
      test_response_hold_off();
      test_drain_pause();
      test_random_gap_mix(9);

      // Let every response come back, then watch for strays.
      wait_results_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (pending_results.size() != 0)
         report_mismatch("responses never returned", 0, pending_results.size());

      if (fail_count == 0)
         $display("bounded_list_insert_delete_search_top: match");
      else
         $display("bounded_list_insert_delete_search_top: mismatch");
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl
rtl/blist_pkg.sv
rtl/blist_dp.sv
rtl/blist_ctrl.sv
rtl/bounded_list_insert_delete_search_top.sv
tb/bounded_list_insert_delete_search_top_tb.sv
